>>> src/crfq_pkg.sv
package crfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int ID_W      = 29;
    localparam int LEN_W     = 4;
    localparam int SRC_W     = 2;
    localparam int PAYLOAD_W = 64;
    localparam int HDR_W     = ID_W + LEN_W + SRC_W;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_crfq_op;

    typedef struct packed {
        t_crfq_op             operation;
        logic [7:0]           id_high_byte;
        logic [7:0]           id_low_byte;
        logic [7:0]           ext_high_byte;
        logic [7:0]           ext_low_byte;
        logic [LEN_W-1:0]     length_code;
        logic [PAYLOAD_W-1:0] payload;
        logic [SRC_W-1:0]     source_buffer;
    } t_crfq_in;

    typedef struct packed {
        logic                 ok;
        logic [ID_W-1:0]      frame_id;
        logic [LEN_W-1:0]     frame_length;
        logic [PAYLOAD_W-1:0] frame_payload;
        logic [SRC_W-1:0]     frame_source;
        logic                 overflow_seen;
    } t_crfq_out;

    // Per-transfer command from the queue controller.
    typedef struct packed {
        logic we;
        logic re;
        logic ok;
        logic ovf;
    } t_crfq_cmd;

    // Queue status, visible for checking.
    typedef struct packed {
        logic full;
        logic empty;
        logic ovf;
    } t_crfq_stat;

    // Packs the raw identifier bytes into the 29-bit extended identifier.
    function automatic logic [ID_W-1:0] crfq_unpack_id(
        input logic [7:0] sidh,
        input logic [7:0] sidl,
        input logic [7:0] eidh,
        input logic [7:0] eidl
    );
        crfq_unpack_id = {sidh, sidl[7:5], sidl[1:0], eidh, eidl};
    endfunction

endpackage

>>> src/crfq_ram.sv
module crfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/crfq_ctrl.sv
module crfq_ctrl #(
    parameter int QUEUE_DEPTH = crfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  crfq_pkg::t_crfq_op             i_op,
    output crfq_pkg::t_crfq_cmd            o_cmd,
    output crfq_pkg::t_crfq_stat           o_stat,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_waddr,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_raddr
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [IDX_W-1:0] r_widx, n_widx;
    logic [IDX_W-1:0] r_ridx, n_ridx;
    logic             r_full, n_full;
    logic             r_ovf,  n_ovf;
    logic             empty;
    logic [IDX_W-1:0] widx_inc, ridx_inc;

    assign empty    = (r_widx == r_ridx) && !r_full;
    assign widx_inc = (r_widx == LAST_IDX) ? '0 : r_widx + IDX_W'(1);
    assign ridx_inc = (r_ridx == LAST_IDX) ? '0 : r_ridx + IDX_W'(1);

    always_comb begin
        n_widx = r_widx;
        n_ridx = r_ridx;
        n_full = r_full;
        n_ovf  = r_ovf;
        o_cmd  = '0;
        if (i_accept) begin
            case (i_op)
                crfq_pkg::OP_PUSH: begin
                    if (r_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        o_cmd.we = 1'b1;
                        o_cmd.ok = 1'b1;
                        n_widx   = widx_inc;
                        n_full   = (widx_inc == r_ridx);
                    end
                end
                crfq_pkg::OP_POP: begin
                    if (!empty) begin
                        o_cmd.re = 1'b1;
                        o_cmd.ok = 1'b1;
                        n_ridx   = ridx_inc;
                        n_full   = 1'b0;
                    end
                end
                default: begin
                    n_ovf = r_ovf;
                end
            endcase
        end
        o_cmd.ovf = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
            r_ridx <= '0;
            r_full <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_widx <= n_widx;
            r_ridx <= n_ridx;
            r_full <= n_full;
            r_ovf  <= n_ovf;
        end
    end

    assign o_stat.full  = r_full;
    assign o_stat.empty = empty;
    assign o_stat.ovf   = r_ovf;
    assign o_waddr      = r_widx;
    assign o_raddr      = r_ridx;

endmodule

>>> src/can_rx_frame_queue.sv
// Receive queue for CAN frames with 29-bit extended identifiers. Each input
// transfer is either a push, carrying the raw SIDH/SIDL/EIDH/EIDL bytes, the
// length code, eight data bytes and the source buffer number, or a pop of
// the oldest stored frame. Every input transfer yields exactly one result
// transfer: ok tells whether the push was stored or the pop found a frame,
// and overflow_seen is the sticky flag set by any push into a full queue
// (only reset clears it). Frame fields are zero unless a pop succeeded. The
// block takes one transfer per cycle while results are taken, and returns
// each result in the cycle after acceptance, via the registered read port
// of the frame memory, read in the cycle the pop is accepted. A finished
// result may wait in the output register while the next transfer is
// accepted, as long as the consumer takes the result in that same cycle.
// Frame memories need no clearing after reset, so the block is ready at once.
module can_rx_frame_queue #(
    parameter int QUEUE_DEPTH = crfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crfq_pkg::t_crfq_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output crfq_pkg::t_crfq_out o_out_data
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    logic                           in_accept;
    crfq_pkg::t_crfq_cmd            cmd;
    crfq_pkg::t_crfq_stat           stat;
    logic [IDX_W-1:0]               waddr;
    logic [IDX_W-1:0]               raddr;
    logic [crfq_pkg::HDR_W-1:0]     hdr_wdata;
    logic [crfq_pkg::HDR_W-1:0]     hdr_rdata;
    logic [crfq_pkg::PAYLOAD_W-1:0] pay_rdata;

    // Result register. The frame fields themselves sit in the memory read
    // registers, which only change when another pop is accepted.
    logic r_out_valid;
    logic r_ok;
    logic r_pop;
    logic r_ovf;

    // A new transfer may enter whenever the result slot is empty or being
    // emptied in this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    crfq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(in_accept),
        .i_op    (i_in_data.operation),
        .o_cmd   (cmd),
        .o_stat  (stat),
        .o_waddr (waddr),
        .o_raddr (raddr)
    );

    // Header layout: identifier, then length code, then source buffer.
    assign hdr_wdata = {crfq_pkg::crfq_unpack_id(i_in_data.id_high_byte,
                                                 i_in_data.id_low_byte,
                                                 i_in_data.ext_high_byte,
                                                 i_in_data.ext_low_byte),
                        i_in_data.length_code,
                        i_in_data.source_buffer};

    crfq_ram #(
        .WIDTH(crfq_pkg::HDR_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_header_store (
        .i_clk  (i_clk),
        .i_we   (cmd.we),
        .i_waddr(waddr),
        .i_wdata(hdr_wdata),
        .i_re   (cmd.re),
        .i_raddr(raddr),
        .o_rdata(hdr_rdata)
    );

    crfq_ram #(
        .WIDTH(crfq_pkg::PAYLOAD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_payload_store (
        .i_clk  (i_clk),
        .i_we   (cmd.we),
        .i_waddr(waddr),
        .i_wdata(i_in_data.payload),
        .i_re   (cmd.re),
        .i_raddr(raddr),
        .o_rdata(pay_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ok  <= cmd.ok;
            r_pop <= cmd.re;
            r_ovf <= cmd.ovf;
        end
    end

    // A push, refused or not, and an empty pop return zero frame fields.
    always_comb begin
        o_out_data               = '0;
        o_out_data.ok            = r_ok;
        o_out_data.overflow_seen = r_ovf;
        if (r_pop) begin
            o_out_data.frame_id      = hdr_rdata[crfq_pkg::HDR_W-1 -: crfq_pkg::ID_W];
            o_out_data.frame_length  = hdr_rdata[crfq_pkg::SRC_W +: crfq_pkg::LEN_W];
            o_out_data.frame_source  = hdr_rdata[crfq_pkg::SRC_W-1:0];
            o_out_data.frame_payload = pay_rdata;
        end
    end

    assign o_out_valid = r_out_valid;

    // The queue can never be full and empty at once.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.full && stat.empty))
        else $error("queue reports full and empty together");

    // Once a push has been refused, the overflow flag stays set.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.ovf |=> stat.ovf)
        else $error("overflow flag cleared without reset");

    // A push into a full queue is refused and reports the overflow.
    a_full_push_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.operation == crfq_pkg::OP_PUSH && stat.full)
        |=> (o_out_valid && !o_out_data.ok && o_out_data.overflow_seen))
        else $error("push into full queue not refused");

    // A refused or empty result carries no frame.
    a_fail_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.ok) |->
        (o_out_data.frame_id == '0 && o_out_data.frame_payload == '0))
        else $error("failed result carries frame data");

endmodule
